// ----- hdl/qtd_pkg.sv -----
// ----------------------------------------------------------------------------
// qtd_pkg: shared types and codes of the quadtree bitmap decoder
// Symbol codes, register indexes, sequencer states and port widths.
// ----------------------------------------------------------------------------
package qtd_pkg;

  localparam int SYM_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int POS_W      = 8;
  localparam int SIZE_W     = 9;
  localparam int NEXT_W     = 3;

  localparam logic [SYM_W-1:0] SYM_LEAF0 = 2'd0;
  localparam logic [SYM_W-1:0] SYM_LEAF1 = 2'd1;
  localparam logic [SYM_W-1:0] SYM_SPLIT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 2'd1;

  // quadrant order: top-left, top-right, bottom-left, bottom-right
  localparam logic [NEXT_W-1:0] QUAD_FIRST = 3'd1;
  localparam logic [NEXT_W-1:0] QUAD_LAST  = 3'd3;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_QUAD = 3'b100
  } state_t;

endpackage

// ----- hdl/quadtree_bitmap_decoder.sv -----
// ----------------------------------------------------------------------------
// quadtree_bitmap_decoder: quadtree symbol stream to filled rectangles
// Decodes split / leaf symbols against a frame stack and emits one
// rectangle per leaf, with image_done on the image's last leaf.
// ----------------------------------------------------------------------------
// Feed one symbol per beat while in_ready is high (0 leaf zero, 1 leaf one, 2 split, 3 ignored).
// A split or an ignored symbol keeps the decoder in its idle state. A leaf is
// taken, then the frame stack is read and the quadrants of the top frame are
// tried until a non-empty quadrant is found; an exhausted frame is dropped
// and the next one read, and one more read finds the stack empty at the
// image's end. This is the work of the single shared quadrant unit and the
// single read port of the frame stack; a frame costs one read and at most
// three quadrant tries. The result stays in the output register until taken
// and the next symbol can be accepted in the beat the result leaves. A
// write to image_rows or image_cols restarts decoding at the root; write
// only while no leaf is in flight. Split symbols arriving with all
// STACK_DEPTH frames in use are dropped.
module quadtree_bitmap_decoder #(
  parameter int MAX_ROWS    = 256,
  parameter int MAX_COLS    = 256,
  parameter int STACK_DEPTH = 9
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [qtd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qtd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [qtd_pkg::SYM_W-1:0]        symbol,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [qtd_pkg::POS_W-1:0]        row_start,
  output logic [qtd_pkg::POS_W-1:0]        col_start,
  output logic [qtd_pkg::SIZE_W-1:0]       height,
  output logic [qtd_pkg::SIZE_W-1:0]       width,
  output logic                             fill_value,
  output logic                             image_done
);

  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef struct packed {
    logic [RW-1:0]                 r;
    logic [CW-1:0]                 c;
    logic [RW-1:0]                 h;
    logic [CW-1:0]                 w;
    logic [qtd_pkg::NEXT_W-1:0]    next;
  } frame_t;

  qtd_pkg::state_t state;

  logic [qtd_pkg::CFG_DATA_W-1:0] image_rows, image_cols;
  logic [qtd_pkg::CFG_DATA_W-1:0] image_rows_next, image_cols_next;
  logic [RW-1:0] root_h;
  logic [CW-1:0] root_w;

  logic [RW-1:0] pend_r, pend_h;
  logic [CW-1:0] pend_c, pend_w;
  logic [LW-1:0] level;
  frame_t        top;
  frame_t        frame_mem [STACK_DEPTH];

  logic          frame_we;
  logic [IW-1:0] frame_waddr;
  frame_t        frame_wdata;
  logic [IW-1:0] top_addr;

  logic [RW-1:0] u_r, u_h, q_r, q_h;
  logic [CW-1:0] u_c, u_w, q_c, q_w;
  logic [1:0]    u_k;
  logic          q_empty;

  logic cfg_fire, in_fire, out_fire, is_leaf, is_split, stack_full;

  assign cfg_ready  = 1'b1;
  assign cfg_fire   = cfg_valid && cfg_ready;
  assign in_ready   = (state == qtd_pkg::ST_IDLE) && (!out_valid || out_ready);
  assign in_fire    = in_valid && in_ready;
  assign out_fire   = out_valid && out_ready;
  assign is_leaf    = (symbol == qtd_pkg::SYM_LEAF0) || (symbol == qtd_pkg::SYM_LEAF1);
  assign is_split   = (symbol == qtd_pkg::SYM_SPLIT);
  assign stack_full = (32'(level) >= 32'(STACK_DEPTH));
  assign top_addr   = IW'(level - LW'(1));

  // restart uses the size being written in the same beat
  always_comb begin
    image_rows_next = image_rows;
    image_cols_next = image_cols;
    if (cfg_fire && cfg_index == qtd_pkg::REG_IMAGE_ROWS) image_rows_next = cfg_data;
    if (cfg_fire && cfg_index == qtd_pkg::REG_IMAGE_COLS) image_cols_next = cfg_data;
    if (image_rows_next == '0) begin
      root_h = RW'(1);
    end else if (32'(image_rows_next) > 32'(MAX_ROWS)) begin
      root_h = RW'(MAX_ROWS);
    end else begin
      root_h = RW'(image_rows_next);
    end
    if (image_cols_next == '0) begin
      root_w = CW'(1);
    end else if (32'(image_cols_next) > 32'(MAX_COLS)) begin
      root_w = CW'(MAX_COLS);
    end else begin
      root_w = CW'(image_cols_next);
    end
  end

  // shared quadrant unit: pending region on a split, stack top while unwinding
  always_comb begin
    if (state == qtd_pkg::ST_QUAD) begin
      u_r = top.r;
      u_c = top.c;
      u_h = top.h;
      u_w = top.w;
      u_k = top.next[1:0];
    end else begin
      u_r = pend_r;
      u_c = pend_c;
      u_h = pend_h;
      u_w = pend_w;
      u_k = 2'd0;
    end
  end

  qtd_quad #(.RW(RW), .CW(CW)) u_quad (
    .r(u_r), .c(u_c), .h(u_h), .w(u_w), .k(u_k),
    .qr(q_r), .qc(q_c), .qh(q_h), .qw(q_w), .empty(q_empty)
  );

  always_comb begin
    frame_we    = 1'b0;
    frame_waddr = top_addr;
    frame_wdata = top;
    if (state == qtd_pkg::ST_IDLE && in_fire && is_split && !stack_full) begin
      frame_we    = 1'b1;
      frame_waddr = IW'(level);
      frame_wdata = '{r: pend_r, c: pend_c, h: pend_h, w: pend_w,
                      next: qtd_pkg::QUAD_FIRST};
    end else if (state == qtd_pkg::ST_QUAD && !top.next[2] && !q_empty) begin
      frame_we         = 1'b1;
      frame_wdata.next = top.next + qtd_pkg::NEXT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (frame_we) frame_mem[frame_waddr] <= frame_wdata;
    if (state == qtd_pkg::ST_READ) top <= frame_mem[top_addr];
    else if (state == qtd_pkg::ST_QUAD) top.next <= top.next + qtd_pkg::NEXT_W'(1);
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == qtd_pkg::ST_IDLE && in_fire && is_leaf) begin
      row_start  <= qtd_pkg::POS_W'(pend_r);
      col_start  <= qtd_pkg::POS_W'(pend_c);
      height     <= qtd_pkg::SIZE_W'(pend_h);
      width      <= qtd_pkg::SIZE_W'(pend_w);
      fill_value <= symbol[0];
    end
    if (state == qtd_pkg::ST_READ && level == '0) image_done <= 1'b1;
    else if (state == qtd_pkg::ST_QUAD) image_done <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= qtd_pkg::ST_IDLE;
      image_rows <= qtd_pkg::CFG_DATA_W'(1);
      image_cols <= qtd_pkg::CFG_DATA_W'(1);
      level      <= '0;
      pend_r     <= '0;
      pend_c     <= '0;
      pend_h     <= RW'(1);
      pend_w     <= CW'(1);
      out_valid  <= 1'b0;
    end else begin
      if (out_fire) out_valid <= 1'b0;
      if (cfg_fire) begin
        image_rows <= image_rows_next;
        image_cols <= image_cols_next;
        // unmapped indexes leave the decode where it is
        if (cfg_index == qtd_pkg::REG_IMAGE_ROWS ||
            cfg_index == qtd_pkg::REG_IMAGE_COLS) begin
          level  <= '0;
          pend_r <= '0;
          pend_c <= '0;
          pend_h <= root_h;
          pend_w <= root_w;
        end
      end
      case (state)
        qtd_pkg::ST_IDLE: begin
          if (in_fire && is_split && !stack_full) begin
            level  <= level + LW'(1);
            pend_r <= q_r;
            pend_c <= q_c;
            pend_h <= q_h;
            pend_w <= q_w;
          end else if (in_fire && is_leaf) begin
            state <= qtd_pkg::ST_READ;
          end
        end
        qtd_pkg::ST_READ: begin
          if (level == '0) begin
            // image complete: restart at the root
            pend_r    <= '0;
            pend_c    <= '0;
            pend_h    <= root_h;
            pend_w    <= root_w;
            out_valid <= 1'b1;
            state     <= qtd_pkg::ST_IDLE;
          end else begin
            state <= qtd_pkg::ST_QUAD;
          end
        end
        qtd_pkg::ST_QUAD: begin
          if (!top.next[2] && !q_empty) begin
            pend_r    <= q_r;
            pend_c    <= q_c;
            pend_h    <= q_h;
            pend_w    <= q_w;
            out_valid <= 1'b1;
            state     <= qtd_pkg::ST_IDLE;
          end else if (top.next[2] || top.next == qtd_pkg::QUAD_LAST) begin
            // frame exhausted: drop it
            level <= level - LW'(1);
            state <= qtd_pkg::ST_READ;
          end
        end
        default: begin
          state <= qtd_pkg::ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    32'(level) <= 32'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_pend_nonempty: assert property (@(posedge clk) disable iff (rst)
    pend_h != '0 && pend_w != '0)
    else $error("pending region has no pixels");

  a_done_empty_stack: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && image_done |-> level == '0 && pend_r == '0 && pend_c == '0)
    else $error("image done with frames still live");

  a_split_push: assert property (@(posedge clk) disable iff (rst)
    in_fire && is_split && !stack_full && !cfg_fire |=> level == $past(level) + LW'(1))
    else $error("split did not push a frame");

  a_leaf_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire && is_leaf |=> !in_ready && !out_valid)
    else $error("leaf result shown before unwind");
`endif

endmodule

// ----- hdl/qtd_quad.sv -----
// ----------------------------------------------------------------------------
// qtd_quad: quadrant unit
// Cuts a region into one of its four quadrants; the first half of each
// dimension takes the rounded-up size. Flags quadrants with no pixels.
// ----------------------------------------------------------------------------
module qtd_quad #(
  parameter int RW = 9,
  parameter int CW = 9
) (
  input  logic [RW-1:0] r,
  input  logic [CW-1:0] c,
  input  logic [RW-1:0] h,
  input  logic [CW-1:0] w,
  input  logic [1:0]    k,
  output logic [RW-1:0] qr,
  output logic [CW-1:0] qc,
  output logic [RW-1:0] qh,
  output logic [CW-1:0] qw,
  output logic          empty
);

  logic [RW-1:0] h1, h2;
  logic [CW-1:0] w1, w2;

  always_comb begin
    h2 = h >> 1;
    h1 = h2 + RW'(h[0]);
    w2 = w >> 1;
    w1 = w2 + CW'(w[0]);
    qr = k[1] ? r + h1 : r;
    qh = k[1] ? h2 : h1;
    qc = k[0] ? c + w1 : c;
    qw = k[0] ? w2 : w1;
    empty = (qh == '0) || (qw == '0);
  end

endmodule
